// ----- src/rtp_sequence_receive_stats_top_defines.svh -----
// Assertion helpers shared by the RTL of the RTP sequence statistics block.
`ifndef RTP_SEQUENCE_RECEIVE_STATS_TOP_DEFINES_SVH
`define RTP_SEQUENCE_RECEIVE_STATS_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTPSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rtpss_pkg.sv -----
`timescale 1ns / 1ps

package rtpss_pkg;

    localparam int SEQ_BITS  = 16;
    localparam int BIT_BITS  = 6;
    localparam int ROW_BITS  = SEQ_BITS - BIT_BITS;
    localparam int WORD_BITS = 1 << BIT_BITS;
    localparam int ROWS      = 1 << ROW_BITS;
    localparam int CNT_BITS  = 32;
    localparam int NUM_CNT   = 7;
    localparam int OUT_WORDS = 9;

    localparam logic [ROW_BITS-1:0] ROW_LAST  = ROW_BITS'(ROWS - 1);
    localparam logic [SEQ_BITS-1:0] SEQ_HALF  = SEQ_BITS'(1 << (SEQ_BITS - 1));

    typedef logic [2:0] req_type_t;
    localparam req_type_t REQ_RECEIVE    = 3'd0;
    localparam req_type_t REQ_SIZE_ERR   = 3'd1;
    localparam req_type_t REQ_AUTH_FAIL  = 3'd2;
    localparam req_type_t REQ_REPLAY     = 3'd3;
    localparam req_type_t REQ_DECRYPT_OK = 3'd4;
    localparam req_type_t REQ_CLEAR      = 3'd5;

    // Event counter slots, also their order in the result word.
    localparam int CNT_RECV    = 0;
    localparam int CNT_SIZE    = 1;
    localparam int CNT_AUTH    = 2;
    localparam int CNT_REPLAY  = 3;
    localparam int CNT_DECRYPT = 4;
    localparam int CNT_DUP     = 5;
    localparam int CNT_OOO     = 6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_EV_RD,
        ST_EV_LOAD,
        ST_EV_BIT,
        ST_EXPECT,
        ST_OUT
    } state_t;

endpackage

// ----- src/rtp_sequence_receive_stats_top.sv -----
`timescale 1ns / 1ps
// Channel  | Direction | tdata                               | tuser
// s_       | in        | [15:0] seq_num                      | [2:0] req_type
// m_       | out       | 9 x 32-bit totals, received lowest  | [0] was_duplicate
// cfg_     | in        | [15:0] history_limit                | none
//
// A receive word holds the block through accept, bitmap update, expected count and
// result load, and its result word is registered at the load; other words skip the update.
// The bitmap is a 1024 x 64 memory, at most one read-modify-write a receive.
// Eviction adds a read, a load and a bit step per row scanned, plus a bit step per sequence number dropped.
// Reset and clear-all run a clearing pass over all 1024 rows, one row per cycle, taking no input.
// A stalled result word holds in the output register while the next event is processed.

`include "rtp_sequence_receive_stats_top_defines.svh"

module rtp_sequence_receive_stats_top (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    // seq_num
    input  logic [15:0]                                           s_tdata,
    // req_type
    input  logic [2:0]                                            s_tuser,
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,
    // received_total, size_error_total, auth_fail_total, replay_total,
    // decrypt_ok_total, duplicate_total, out_of_order_total, expected_total,
    // lost_total
    output logic [rtpss_pkg::OUT_WORDS*rtpss_pkg::CNT_BITS-1:0] m_tdata,
    // was_duplicate
    output logic [0:0]                                            m_tuser,
    output logic                                                  m_tvalid,
    input  logic                                                  m_tready,
    // history_limit
    input  logic [15:0]                                           cfg_data,
    input  logic                                                  cfg_valid,
    output logic                                                  cfg_ready
);

    import rtpss_pkg::*;

    // Seen-sequence bitmap, one row of 64 sequence numbers per entry.
    logic [WORD_BITS-1:0] bitmap_mem [ROWS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [ROW_BITS-1:0]  rd_addr;
    logic                 mem_we;
    logic [ROW_BITS-1:0]  mem_wa;
    logic [WORD_BITS-1:0] mem_wd;

    state_t               state_reg, state_next;
    logic [ROW_BITS-1:0]  clr_row_reg, clr_row_next;
    logic                 clr_result_reg, clr_result_next;
    logic [15:0]          limit_reg, limit_next;

    logic [SEQ_BITS:0]    seen_count_reg, seen_count_next;
    logic [SEQ_BITS-1:0]  low_reg, low_next;
    logic [SEQ_BITS-1:0]  high_reg, high_next;
    logic [15:0]          wrap_reg, wrap_next;
    logic                 started_reg, started_next;
    logic [CNT_BITS-1:0]  cnt_reg [NUM_CNT];
    logic [CNT_BITS-1:0]  cnt_next [NUM_CNT];

    logic [ROW_BITS-1:0]  ev_row_reg, ev_row_next;
    logic [13:0]          ev_left_reg, ev_left_next;
    logic [WORD_BITS-1:0] ev_word_reg, ev_word_next;

    logic [SEQ_BITS-1:0]  seq_reg, seq_next;
    logic                 dup_reg, dup_next;
    logic [CNT_BITS-1:0]  exp_reg, exp_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_WORDS*CNT_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    // Serial-number distances of the current sequence to the tracked range.
    logic [SEQ_BITS-1:0]  d_high, d_low;
    logic                 seq_ahead, seq_behind;
    logic [SEQ_BITS:0]    count_inc;
    logic [CNT_BITS-1:0]  lost_val;

    assign d_high     = seq_reg - high_reg;
    assign d_low      = seq_reg - low_reg;
    assign seq_ahead  = (d_high != '0) && (d_high < SEQ_HALF);
    assign seq_behind = (d_low > SEQ_HALF);
    assign count_inc  = seen_count_reg + 1'b1;
    assign lost_val   = (exp_reg > cnt_reg[CNT_RECV]) ? exp_reg - cnt_reg[CNT_RECV] : '0;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // The row of an arriving sequence is read while the word is accepted, so its
    // bits are ready in the update cycle; eviction reads its scan row.
    assign rd_addr = (state_reg == ST_IDLE) ? s_tdata[SEQ_BITS-1:BIT_BITS] : ev_row_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bitmap_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= bitmap_mem[rd_addr];
    end

    always_comb begin
        state_next      = state_reg;
        clr_row_next    = clr_row_reg;
        clr_result_next = clr_result_reg;
        limit_next      = cfg_valid ? cfg_data : limit_reg;
        seen_count_next = seen_count_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        wrap_next       = wrap_reg;
        started_next    = started_reg;
        cnt_next        = cnt_reg;
        ev_row_next     = ev_row_reg;
        ev_left_next    = ev_left_reg;
        ev_word_next    = ev_word_reg;
        seq_next        = seq_reg;
        dup_next        = dup_reg;
        exp_next        = exp_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        mem_we          = 1'b0;
        mem_wa          = ev_row_reg;
        mem_wd          = ev_word_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_wa       = clr_row_reg;
                mem_wd       = '0;
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == ROW_LAST) begin
                    state_next      = clr_result_reg ? ST_EXPECT : ST_IDLE;
                    clr_result_next = 1'b0;
                end
            end

            ST_IDLE: begin
                if (s_tvalid) begin
                    seq_next = s_tdata[SEQ_BITS-1:0];
                    dup_next = 1'b0;
                    unique case (s_tuser)
                        REQ_RECEIVE: begin
                            state_next = ST_UPDATE;
                        end
                        REQ_SIZE_ERR: begin
                            cnt_next[CNT_SIZE] = cnt_reg[CNT_SIZE] + 1'b1;
                            state_next         = ST_EXPECT;
                        end
                        REQ_AUTH_FAIL: begin
                            cnt_next[CNT_AUTH] = cnt_reg[CNT_AUTH] + 1'b1;
                            state_next         = ST_EXPECT;
                        end
                        REQ_REPLAY: begin
                            cnt_next[CNT_REPLAY] = cnt_reg[CNT_REPLAY] + 1'b1;
                            state_next           = ST_EXPECT;
                        end
                        REQ_DECRYPT_OK: begin
                            cnt_next[CNT_DECRYPT] = cnt_reg[CNT_DECRYPT] + 1'b1;
                            state_next            = ST_EXPECT;
                        end
                        REQ_CLEAR: begin
                            for (int i = 0; i < NUM_CNT; i++) begin
                                cnt_next[i] = '0;
                            end
                            seen_count_next = '0;
                            low_next        = '0;
                            high_next       = '0;
                            wrap_next       = '0;
                            started_next    = 1'b0;
                            clr_row_next    = '0;
                            clr_result_next = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_EXPECT;
                        end
                    endcase
                end
            end

            ST_UPDATE: begin
                state_next = ST_EXPECT;
                if (rd_data_reg[seq_reg[BIT_BITS-1:0]]) begin
                    dup_next          = 1'b1;
                    cnt_next[CNT_DUP] = cnt_reg[CNT_DUP] + 1'b1;
                end else begin
                    mem_we             = 1'b1;
                    mem_wa             = seq_reg[SEQ_BITS-1:BIT_BITS];
                    mem_wd             = rd_data_reg |
                                         (WORD_BITS'(1) << seq_reg[BIT_BITS-1:0]);
                    seen_count_next    = count_inc;
                    cnt_next[CNT_RECV] = cnt_reg[CNT_RECV] + 1'b1;
                    if (!started_reg) begin
                        low_next     = seq_reg;
                        high_next    = seq_reg;
                        wrap_next    = '0;
                        started_next = 1'b1;
                    end else begin
                        if (seq_ahead) begin
                            // A newer sequence below the old maximum has crossed zero.
                            if (seq_reg < high_reg) begin
                                wrap_next = wrap_reg + 1'b1;
                            end
                            high_next = seq_reg;
                        end else if (seq_behind) begin
                            low_next = seq_reg;
                        end else if (seq_reg != high_reg) begin
                            cnt_next[CNT_OOO] = cnt_reg[CNT_OOO] + 1'b1;
                        end
                        if ((count_inc > {1'b0, limit_reg}) && (limit_reg[15:2] != '0)) begin
                            ev_left_next = limit_reg[15:2];
                            ev_row_next  = '0;
                            state_next   = ST_EV_RD;
                        end
                    end
                end
            end

            ST_EV_RD: begin
                state_next = ST_EV_LOAD;
            end

            ST_EV_LOAD: begin
                ev_word_next = rd_data_reg;
                state_next   = ST_EV_BIT;
            end

            ST_EV_BIT: begin
                if ((ev_word_reg == '0) || (ev_left_reg == '0)) begin
                    mem_we = 1'b1;
                    if ((ev_left_reg == '0) || (ev_row_reg == ROW_LAST)) begin
                        state_next = ST_EXPECT;
                    end else begin
                        ev_row_next = ev_row_reg + 1'b1;
                        state_next  = ST_EV_RD;
                    end
                end else begin
                    // Drop the lowest remembered sequence number of this row.
                    ev_word_next    = ev_word_reg & (ev_word_reg - 1'b1);
                    seen_count_next = seen_count_reg - 1'b1;
                    ev_left_next    = ev_left_reg - 1'b1;
                end
            end

            ST_EXPECT: begin
                if (!started_reg || (cnt_reg[CNT_RECV] == '0)) begin
                    exp_next = '0;
                end else if (wrap_reg != '0) begin
                    exp_next = {wrap_reg, high_reg} - {16'd0, low_reg} + 1'b1;
                end else begin
                    exp_next = {16'd0, SEQ_BITS'(high_reg - low_reg)} + 1'b1;
                end
                state_next = ST_OUT;
            end

            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    for (int i = 0; i < NUM_CNT; i++) begin
                        m_tdata_next[i*CNT_BITS +: CNT_BITS] = cnt_reg[i];
                    end
                    m_tdata_next[NUM_CNT*CNT_BITS +: CNT_BITS]       = exp_reg;
                    m_tdata_next[(NUM_CNT+1)*CNT_BITS +: CNT_BITS]   = lost_val;
                    m_tuser_next  = dup_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_row_reg    <= '0;
            clr_result_reg <= 1'b0;
            limit_reg      <= 16'd1024;
            seen_count_reg <= '0;
            low_reg        <= '0;
            high_reg       <= '0;
            wrap_reg       <= '0;
            started_reg    <= 1'b0;
            for (int i = 0; i < NUM_CNT; i++) begin
                cnt_reg[i] <= '0;
            end
            ev_row_reg     <= '0;
            ev_left_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_row_reg    <= clr_row_next;
            clr_result_reg <= clr_result_next;
            limit_reg      <= limit_next;
            seen_count_reg <= seen_count_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            wrap_reg       <= wrap_next;
            started_reg    <= started_next;
            cnt_reg        <= cnt_next;
            ev_row_reg     <= ev_row_next;
            ev_left_reg    <= ev_left_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ev_word_reg <= ev_word_next;
        seq_reg     <= seq_next;
        dup_reg     <= dup_next;
        exp_reg     <= exp_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // A started record always holds at least one sequence number, since an eviction
    // drops only a quarter of the limit from a record above the limit.
    `RTPSS_ASSERT_IMP(a_started_count, aclk, aresetn, started_reg, seen_count_reg != '0, "started with empty record")

    // An eviction scan is entered only with sequence numbers left to drop.
    `RTPSS_ASSERT_IMP(a_evict_left, aclk, aresetn, state_reg == ST_EV_RD, ev_left_reg != '0, "eviction scan with nothing to drop")

    // The record always holds enough bits to finish an eviction within the bitmap.
    `RTPSS_ASSERT_IMP(a_evict_end, aclk, aresetn, (state_reg == ST_EV_BIT) && (ev_word_reg == '0) && (ev_row_reg == ROW_LAST), ev_left_reg == '0, "eviction ran past last row")

    // A result that is ready to load always shows up on the output next cycle.
    `RTPSS_ASSERT_NEXT(a_result_loaded, aclk, aresetn, (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready), m_tvalid_reg && (state_reg == ST_IDLE), "result word not loaded")

endmodule

// ----- verif/tb_rtp_sequence_receive_stats_top.sv -----
`timescale 1ns / 1ps

module tb_rtp_sequence_receive_stats_top;

    import rtpss_pkg::*;

    // The two event codes that the block does not define. They must leave every
    // counter alone and still produce a result word.
    localparam req_type_t REQ_RESERVED_A = 3'd6;
    localparam req_type_t REQ_RESERVED_B = 3'd7;

    // Positions of the two derived totals in the result word, after the counters.
    localparam int WORD_EXPECTED = NUM_CNT;
    localparam int WORD_LOST     = NUM_CNT + 1;

    localparam logic [15:0] LIMIT_AT_RESET  = 16'd1024;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          NUM_PHASES      = 7;
    localparam int          PHASE_EVENTS    = 80;
    localparam int          FLOOD_EVENTS    = 24;

    // One result word, split into its fields.
    typedef struct packed {
        logic        was_dup;
        logic [31:0] received;
        logic [31:0] size_errs;
        logic [31:0] auth_fails;
        logic [31:0] replays;
        logic [31:0] decrypt_oks;
        logic [31:0] duplicates;
        logic [31:0] out_of_order;
        logic [31:0] expected_pkts;
        logic [31:0] lost_pkts;
    } stats_t;

    // One packet event. Where hand_typed is set, the duplicate flag and the
    // received, expected and lost totals are written out by hand and replace
    // the predicted ones.
    typedef struct packed {
        req_type_t   kind;
        logic [15:0] seq;
        logic        hand_typed;
        logic        dup;
        logic [31:0] recv;
        logic [31:0] expct;
        logic [31:0] lost;
    } event_row_t;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic [15:0]                     s_tdata;
    logic [2:0]                      s_tuser;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [OUT_WORDS*CNT_BITS-1:0]   m_tdata;
    logic [0:0]                      m_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [15:0]                     cfg_data;
    logic                            cfg_valid;
    logic                            cfg_ready;

    rtp_sequence_receive_stats_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    // A 2 ns clock. Stimulus moves on the falling edge, so every input is
    // stable a half period before the rising edge that samples it.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow copy of the block's state, kept by the predictor below.
    logic [63:0]  seen_rows [ROWS];
    int unsigned  seen_cnt;
    logic [15:0]  low_seq;
    logic [15:0]  high_seq;
    logic [15:0]  wrap_count;
    logic         tracking;
    logic [31:0]  event_cnt [NUM_CNT];
    logic [15:0]  hist_limit;

    // Result words still owed by the block, oldest first.
    stats_t       pending_stats [$];

    stats_t       seen_word;
    stats_t       due_word;
    int unsigned  errors;
    int unsigned  items_sent;
    int unsigned  words_checked;
    int unsigned  dup_hits;
    int unsigned  clears;
    logic [15:0]  cursor;
    bit           tx_steady;
    bit           rx_steady;
    bit           hold_off_req;
    int unsigned  stall_left;

    logic [15:0]  phase_limits [NUM_PHASES] = '{16'd4, 16'd16, 16'd3, 16'd65535,
                                                16'd7, 16'd64, 16'd4};

    // The directed part. The first rows walk through a reserved event, the
    // first packet, a duplicate, a sequence exactly half the number space
    // away from the highest one, and a newer one, all with hand-typed
    // totals. Then the lowest is moved back across zero, the highest climbs
    // until it wraps, every other event kind appears once, and a clear brings
    // the totals back to zero before a last receive and reserved event.
    event_row_t directed_tbl [19] = '{
        {REQ_RESERVED_A, 16'h1234, 1'b1, 1'b0, 32'd0, 32'd0,  32'd0},
        {REQ_RECEIVE,    16'h0000, 1'b1, 1'b0, 32'd1, 32'd1,  32'd0},
        {REQ_RECEIVE,    16'h0000, 1'b1, 1'b1, 32'd1, 32'd1,  32'd0},
        {REQ_RECEIVE,    16'h8000, 1'b1, 1'b0, 32'd2, 32'd1,  32'd0},
        {REQ_RECEIVE,    16'h0010, 1'b1, 1'b0, 32'd3, 32'd17, 32'd14},
        {REQ_RECEIVE,    16'hFFFF, 1'b0, 1'b0, 32'd0, 32'd0,  32'd0},
        {REQ_RECEIVE,    16'h4000, 1'b0, 1'b0, 32'd0, 32'd0,  32'd0},
        {REQ_RECEIVE,    16'h8100, 1'b0, 1'b0, 32'd0, 32'd0,  32'd0},
        {REQ_RECEIVE,    16'hC000, 1'b0, 1'b0, 32'd0, 32'd0,  32'd0},
        {REQ_RECEIVE,    16'h0005, 1'b0, 1'b0, 32'd0, 32'd0,  32'd0},
        {REQ_SIZE_ERR,   16'hFFFF, 1'b0, 1'b0, 32'd0, 32'd0,  32'd0},
        {REQ_AUTH_FAIL,  16'h0000, 1'b0, 1'b0, 32'd0, 32'd0,  32'd0},
        {REQ_REPLAY,     16'hAAAA, 1'b0, 1'b0, 32'd0, 32'd0,  32'd0},
        {REQ_DECRYPT_OK, 16'h5555, 1'b0, 1'b0, 32'd0, 32'd0,  32'd0},
        {REQ_RESERVED_B, 16'hFFFF, 1'b0, 1'b0, 32'd0, 32'd0,  32'd0},
        {REQ_RECEIVE,    16'h4000, 1'b0, 1'b0, 32'd0, 32'd0,  32'd0},
        {REQ_CLEAR,      16'h0000, 1'b1, 1'b0, 32'd0, 32'd0,  32'd0},
        {REQ_RECEIVE,    16'hFFFF, 1'b1, 1'b0, 32'd1, 32'd1,  32'd0},
        {REQ_RESERVED_A, 16'h0000, 1'b1, 1'b0, 32'd1, 32'd1,  32'd0}
    };

    // Returns every piece of shadow state to its reset value. The history
    // limit is a register and survives.
    function automatic void clear_tracking();
        int row;
        for (row = 0; row < ROWS; row++)
            seen_rows[row] = '0;
        for (row = 0; row < NUM_CNT; row++)
            event_cnt[row] = '0;
        seen_cnt   = 0;
        low_seq    = '0;
        high_seq   = '0;
        wrap_count = '0;
        tracking   = 1'b0;
    endfunction

    // Applies one packet event to the shadow state and returns the result
    // word that the block must produce for it.
    function automatic stats_t apply_event(req_type_t kind, logic [15:0] seq);
        stats_t      res;
        logic [31:0] pos;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] drop;
        logic [31:0] span;
        int          row;
        res = '0;
        unique case (kind)
            REQ_RECEIVE: begin
                if (seen_rows[seq[15:6]][seq[5:0]]) begin
                    event_cnt[CNT_DUP] += 1;
                    res.was_dup = 1'b1;
                end else begin
                    seen_rows[seq[15:6]][seq[5:0]] = 1'b1;
                    seen_cnt += 1;
                    event_cnt[CNT_RECV] += 1;
                    if (!tracking) begin
                        low_seq    = seq;
                        high_seq   = seq;
                        wrap_count = '0;
                        tracking   = 1'b1;
                    end else begin
                        pos = seq;
                        hi  = high_seq;
                        lo  = low_seq;
                        // Serial-number arithmetic: a distance of exactly half
                        // the space is neither newer nor older.
                        if ((pos > hi && pos - hi < SEQ_HALF) ||
                            (pos < hi && hi - pos > SEQ_HALF)) begin
                            if (pos < hi)
                                wrap_count += 1;
                            high_seq = seq;
                        end else if ((pos < lo && lo - pos < SEQ_HALF) ||
                                     (pos > lo && pos - lo > SEQ_HALF)) begin
                            low_seq = seq;
                        end else if (seq != high_seq) begin
                            event_cnt[CNT_OOO] += 1;
                        end
                        // Over the limit, a quarter of the limit goes, numerically lowest first.
                        if (seen_cnt > hist_limit) begin
                            drop = hist_limit / 4;
                            for (row = 0; row < ROWS && drop != 0; row++) begin
                                while (seen_rows[row] != '0 && drop != 0) begin
                                    seen_rows[row] &= seen_rows[row] - 64'd1;
                                    seen_cnt -= 1;
                                    drop     -= 1;
                                end
                            end
                        end
                    end
                end
            end
            REQ_SIZE_ERR:   event_cnt[CNT_SIZE]    += 1;
            REQ_AUTH_FAIL:  event_cnt[CNT_AUTH]    += 1;
            REQ_REPLAY:     event_cnt[CNT_REPLAY]  += 1;
            REQ_DECRYPT_OK: event_cnt[CNT_DECRYPT] += 1;
            REQ_CLEAR:      clear_tracking();
            default: ;
        endcase

        hi = high_seq;
        lo = low_seq;
        if (!tracking || event_cnt[CNT_RECV] == '0)
            span = '0;
        else if (wrap_count != '0)
            span = {wrap_count, high_seq} - lo + 32'd1;
        else if (hi >= lo)
            span = hi - lo + 32'd1;
        else
            span = 32'd65536 - lo + hi + 32'd1;

        res.received      = event_cnt[CNT_RECV];
        res.size_errs     = event_cnt[CNT_SIZE];
        res.auth_fails    = event_cnt[CNT_AUTH];
        res.replays       = event_cnt[CNT_REPLAY];
        res.decrypt_oks   = event_cnt[CNT_DECRYPT];
        res.duplicates    = event_cnt[CNT_DUP];
        res.out_of_order  = event_cnt[CNT_OOO];
        res.expected_pkts = span;
        res.lost_pkts     = (span > event_cnt[CNT_RECV]) ? span - event_cnt[CNT_RECV] : '0;
        return res;
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 16);
        return $urandom_range(40, 120);
    endfunction

    // Random traffic that looks like a real stream: a cursor that mostly
    // steps forward, late and repeated packets behind it, some jumps and
    // half-space hops, and a share of the other event kinds.
    function automatic event_row_t pick_event();
        event_row_t  ev;
        int unsigned roll;
        ev      = '0;
        ev.kind = REQ_RECEIVE;
        roll    = $urandom_range(0, 99);
        if (roll < 55) begin
            cursor += 16'($urandom_range(1, 4));
            ev.seq  = cursor;
        end else if (roll < 65) begin
            ev.seq = cursor - 16'($urandom_range(0, 40));
        end else if (roll < 68) begin
            ev.seq = cursor ^ SEQ_HALF;
        end else if (roll < 72) begin
            ev.seq = 16'($urandom);
        end else if (roll < 75) begin
            cursor += 16'($urandom_range(100, 30000));
            ev.seq  = cursor;
        end else begin
            ev.seq = 16'($urandom);
            if (roll < 93)
                ev.kind = 3'($urandom_range(REQ_SIZE_ERR, REQ_DECRYPT_OK));
            else if (roll < 98)
                ev.kind = $urandom_range(0, 1) ? REQ_RESERVED_A : REQ_RESERVED_B;
            else
                ev.kind = REQ_CLEAR;
        end
        return ev;
    endfunction

    // Offers one event word, waits for it to be taken and records the
    // result word that it is owed. A word that follows without a gap keeps
    // tvalid high.
    task automatic send_event(input event_row_t ev);
        stats_t      due;
        int unsigned gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap != 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= ev.seq;
        s_tuser  <= ev.kind;
        do @(posedge aclk); while (!s_tready);
        due = apply_event(ev.kind, ev.seq);
        if (ev.hand_typed) begin
            due.was_dup       = ev.dup;
            due.received      = ev.recv;
            due.expected_pkts = ev.expct;
            due.lost_pkts     = ev.lost;
        end
        pending_stats.push_back(due);
        items_sent++;
        if (due.was_dup)
            dup_hits++;
        if (ev.kind == REQ_CLEAR)
            clears++;
    endtask

    // Stops offering words and waits until every owed result has arrived.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge aclk);
    endtask

    // The limit is only changed while the block has nothing in flight.
    task automatic write_history_limit(input logic [15:0] value);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        hist_limit = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Result side. The receiver stalls at random, except in its steady
    // phase, and once holds off for a long counted stretch so that the block
    // backs up and stops taking event words.
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end else if (stall_left == 0 && !rx_steady) begin
                stall_left = pick_gap();
            end
            if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Every accepted result word is compared with the oldest owed one.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_stats.size() == 0) begin
                $error("result word arrived with no event outstanding");
                errors++;
            end else begin
                due_word                = pending_stats.pop_front();
                seen_word.was_dup       = m_tuser[0];
                seen_word.received      = m_tdata[CNT_RECV*CNT_BITS +: CNT_BITS];
                seen_word.size_errs     = m_tdata[CNT_SIZE*CNT_BITS +: CNT_BITS];
                seen_word.auth_fails    = m_tdata[CNT_AUTH*CNT_BITS +: CNT_BITS];
                seen_word.replays       = m_tdata[CNT_REPLAY*CNT_BITS +: CNT_BITS];
                seen_word.decrypt_oks   = m_tdata[CNT_DECRYPT*CNT_BITS +: CNT_BITS];
                seen_word.duplicates    = m_tdata[CNT_DUP*CNT_BITS +: CNT_BITS];
                seen_word.out_of_order  = m_tdata[CNT_OOO*CNT_BITS +: CNT_BITS];
                seen_word.expected_pkts = m_tdata[WORD_EXPECTED*CNT_BITS +: CNT_BITS];
                seen_word.lost_pkts     = m_tdata[WORD_LOST*CNT_BITS +: CNT_BITS];
                check_field("was_duplicate", 32'(due_word.was_dup), 32'(seen_word.was_dup));
                check_field("received_total", due_word.received, seen_word.received);
                check_field("size_error_total", due_word.size_errs, seen_word.size_errs);
                check_field("auth_fail_total", due_word.auth_fails, seen_word.auth_fails);
                check_field("replay_total", due_word.replays, seen_word.replays);
                check_field("decrypt_ok_total", due_word.decrypt_oks, seen_word.decrypt_oks);
                check_field("duplicate_total", due_word.duplicates, seen_word.duplicates);
                check_field("out_of_order_total", due_word.out_of_order,
                            seen_word.out_of_order);
                check_field("expected_total", due_word.expected_pkts,
                            seen_word.expected_pkts);
                check_field("lost_total", due_word.lost_pkts, seen_word.lost_pkts);
                words_checked++;
            end
        end
    end

    // Main sequence: reset, the directed table at the reset limit, then one
    // random phase per limit setting. Each phase starts the cursor either
    // just below the top of the sequence space, so that the highest sequence
    // soon wraps, or anywhere at random.
    initial begin
        int i;
        int phase;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        errors       = 0;
        items_sent   = 0;
        words_checked = 0;
        dup_hits     = 0;
        clears       = 0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        hold_off_req = 1'b0;
        cursor       = '0;
        clear_tracking();
        hist_limit   = LIMIT_AT_RESET;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_tbl[i])
            send_event(directed_tbl[i]);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            write_history_limit(phase_limits[phase]);
            cursor    = $urandom_range(0, 1) ? 16'($urandom_range(65000, 65535))
                                             : 16'($urandom);
            tx_steady = (phase == 2);
            rx_steady = (phase == 5);
            // With no eviction at the largest limit, this phase is the cheap
            // place to flood the block while the receiver holds off.
            if (phase == 3) begin
                hold_off_req = 1'b1;
                tx_steady    = 1'b1;
                for (i = 0; i < FLOOD_EVENTS; i++)
                    send_event(pick_event());
                tx_steady = 1'b0;
            end
            for (i = 0; i < PHASE_EVENTS; i++)
                send_event(pick_event());
        end

        drain_results();
        repeat (64) @(posedge aclk);

        $display("Sent %0d packet events, %0d of them duplicates and %0d clears,",
                 items_sent, dup_hits, clears);
        $display("across %0d history limits; %0d result words compared field by field.",
                 NUM_PHASES + 1, words_checked);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog, several times the slowest legal run including the clearing
    // passes and the longest eviction scans.
    initial begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/rtpss_pkg.sv
src/rtp_sequence_receive_stats_top.sv
verif/tb_rtp_sequence_receive_stats_top.sv
